@@ hw/rtl/pis_pkg.sv @@
// Shared constants and types of the partial index shuffle unit.
`timescale 1ns / 1ps

package pis_pkg;

    localparam int CFG_W           = 7;
    localparam int CFG_IDX_W       = 2;
    localparam int RAND_W          = 32;
    localparam int OUT_W           = 6;
    localparam int RESULT_LIMIT    = 64;
    localparam int MAX_ITEMS_DEF   = 64;
    localparam int RANDOM_BITS_DEF = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_LIST_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WANTED_COUNT = 2'd1;

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_DIV       = 9'b000000010,
        ST_RD        = 9'b000000100,
        ST_SWAP_I    = 9'b000001000,
        ST_SWAP_J    = 9'b000010000,
        ST_EMIT_RD   = 9'b000100000,
        ST_EMIT_WAIT = 9'b001000000,
        ST_EMIT_OUT  = 9'b010000000,
        ST_CLEAR     = 9'b100000000
    } t_state;

endpackage

@@ hw/rtl/pis_mod_unit.sv @@
// Bit-serial remainder unit: random word modulo a small divisor.
`timescale 1ns / 1ps

module pis_mod_unit #(
    parameter int RANDOM_BITS = pis_pkg::RANDOM_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pis_pkg::RAND_W-1:0]    i_dividend,
    input  logic [pis_pkg::CFG_W-1:0]     i_divisor,
    output logic                          o_done,
    output logic [pis_pkg::CFG_W-1:0]     o_rem
);

    // Only the low bits of the word that the port can carry take part.
    localparam int UB = (RANDOM_BITS > pis_pkg::RAND_W) ? pis_pkg::RAND_W : RANDOM_BITS;
    localparam int CW = $clog2(UB + 1);
    localparam int RW = pis_pkg::CFG_W;

    logic [UB-1:0] r_dvd, n_dvd;
    logic [RW-1:0] r_rem, n_rem;
    logic [RW-1:0] r_div, n_div;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [RW:0]   w_trial;
    logic [RW:0]   w_diff;

    assign w_trial = {r_rem, r_dvd[UB-1]};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_comb begin
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_div  = r_div;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_dvd  = i_dividend[UB-1:0];
            n_rem  = '0;
            n_div  = i_divisor;
            n_cnt  = CW'(UB);
            n_busy = 1'b1;
        end else if (r_busy) begin
            // Restoring step: the partial remainder stays below the divisor.
            if (w_trial >= {1'b0, r_div}) begin
                n_rem = w_diff[RW-1:0];
            end else begin
                n_rem = w_trial[RW-1:0];
            end
            n_dvd = r_dvd << 1;
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

@@ hw/rtl/pis_ram.sv @@
// Index table memory: one write port, two registered read ports.
`timescale 1ns / 1ps

module pis_ram #(
    parameter int DEPTH = pis_pkg::MAX_ITEMS_DEF,
    parameter int DW    = $clog2(pis_pkg::MAX_ITEMS_DEF)
) (
    input  logic                     i_clk,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_ra0,
    input  logic [$clog2(DEPTH)-1:0] i_ra1,
    output logic [DW-1:0]            o_rd0,
    output logic [DW-1:0]            o_rd1,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wa,
    input  logic [DW-1:0]            i_wd
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd0;
    logic [DW-1:0] r_rd1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        if (i_re) begin
            r_rd0 <= r_mem[i_ra0];
            r_rd1 <= r_mem[i_ra1];
        end
    end

    assign o_rd0 = r_rd0;
    assign o_rd1 = r_rd1;

endmodule

@@ hw/rtl/partial_index_shuffle_unit.sv @@
// Top level of the partial index shuffle unit: sequencer, configuration and output.
// A swap beat runs the bit-serial remainder unit over min(RANDOM_BITS, 32) used random bits,
// then the table read and two write-backs follow.
// After the last swap each result beat is read, registered and held until o_valid is
// taken, then the touched table entries are rewritten to identity, one per cycle,
// and the unit returns to idle.
// Synchronous active-low reset restores the configuration registers to 64 and runs an
// identity pass over min(MAX_ITEMS, 127) entries during which no input beat is accepted.
`timescale 1ns / 1ps

module partial_index_shuffle_unit #(
    parameter int MAX_ITEMS   = pis_pkg::MAX_ITEMS_DEF,
    parameter int RANDOM_BITS = pis_pkg::RANDOM_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pis_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pis_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [pis_pkg::RAND_W-1:0]      i_random_word,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [pis_pkg::OUT_W-1:0]       o_chosen_index,
    output logic                            o_last_of_run
);

    localparam int AW     = $clog2(MAX_ITEMS);
    localparam int DW     = AW;
    localparam int LW     = pis_pkg::CFG_W;
    localparam int LMAX   = (1 << LW) - 1;
    localparam int MAXLEN = (MAX_ITEMS > LMAX) ? LMAX : MAX_ITEMS;

    pis_pkg::t_state r_state, n_state;

    logic [LW-1:0] r_list_len, n_list_len;
    logic [LW-1:0] r_wanted, n_wanted;
    logic [LW-1:0] r_pos, n_pos;
    logic [LW-1:0] r_i, n_i;
    logic [LW-1:0] r_j, n_j;
    logic [LW-1:0] r_cnt, n_cnt;
    logic [LW-1:0] r_w, n_w;
    logic [LW-1:0] r_span, n_span;
    logic          r_ovalid, n_ovalid;
    logic [pis_pkg::OUT_W-1:0] r_out_idx, n_out_idx;
    logic          r_out_last, n_out_last;

    logic [LW-1:0] w_len;
    logic [LW-1:0] w_pos_sel;
    logic [LW-1:0] w_want;
    logic          w_accept;
    logic          w_mod_start;
    logic          w_mod_done;
    logic [LW-1:0] w_mod_rem;

    logic          w_re;
    logic [AW-1:0] w_ra0;
    logic [AW-1:0] w_ra1;
    logic [DW-1:0] w_rd0;
    logic [DW-1:0] w_rd1;
    logic          w_we;
    logic [AW-1:0] w_wa;
    logic [DW-1:0] w_wd;

    assign w_len = (r_list_len > LW'(MAXLEN)) ? LW'(MAXLEN) : r_list_len;

    // A stale or spent position restarts at the top of the list.
    assign w_pos_sel = (r_pos >= w_len || r_pos == '0) ? (w_len - 1'b1) : r_pos;

    always_comb begin
        w_want = (r_wanted > w_len) ? w_len : r_wanted;
        if (w_want > LW'(pis_pkg::RESULT_LIMIT)) begin
            w_want = LW'(pis_pkg::RESULT_LIMIT);
        end
    end

    assign o_ready     = (r_state == pis_pkg::ST_IDLE);
    assign w_accept    = i_valid && o_ready;
    assign w_mod_start = w_accept && (w_len > LW'(1));

    pis_mod_unit #(
        .RANDOM_BITS (RANDOM_BITS)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (i_random_word),
        .i_divisor  (w_pos_sel + 1'b1),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    pis_ram #(
        .DEPTH (MAX_ITEMS),
        .DW    (DW)
    ) u_ram (
        .i_clk (i_clk),
        .i_re  (w_re),
        .i_ra0 (w_ra0),
        .i_ra1 (w_ra1),
        .o_rd0 (w_rd0),
        .o_rd1 (w_rd1),
        .i_we  (w_we),
        .i_wa  (w_wa),
        .i_wd  (w_wd)
    );

    always_comb begin
        n_state    = r_state;
        n_list_len = r_list_len;
        n_wanted   = r_wanted;
        n_pos      = r_pos;
        n_i        = r_i;
        n_j        = r_j;
        n_cnt      = r_cnt;
        n_w        = r_w;
        n_span     = r_span;
        n_ovalid   = r_ovalid;
        n_out_idx  = r_out_idx;
        n_out_last = r_out_last;
        w_re       = 1'b0;
        w_ra0      = AW'(r_i);
        w_ra1      = AW'(r_j);
        w_we       = 1'b0;
        w_wa       = AW'(r_i);
        w_wd       = w_rd1;

        case (r_state)
            pis_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_i = w_pos_sel;
                    if (w_len > LW'(1)) begin
                        n_state = pis_pkg::ST_DIV;
                    end else begin
                        // Nothing to swap: the word is spent and the list goes out.
                        n_pos = '0;
                        n_cnt = '0;
                        n_w   = w_want;
                        n_state = (w_want == '0) ? pis_pkg::ST_CLEAR : pis_pkg::ST_EMIT_RD;
                    end
                end
            end
            pis_pkg::ST_DIV: begin
                if (w_mod_done) begin
                    n_j     = w_mod_rem;
                    n_state = pis_pkg::ST_RD;
                end
            end
            pis_pkg::ST_RD: begin
                w_re    = 1'b1;
                n_state = pis_pkg::ST_SWAP_I;
            end
            pis_pkg::ST_SWAP_I: begin
                w_we    = 1'b1;
                w_wa    = AW'(r_i);
                w_wd    = w_rd1;
                n_state = pis_pkg::ST_SWAP_J;
            end
            pis_pkg::ST_SWAP_J: begin
                w_we = 1'b1;
                w_wa = AW'(r_j);
                w_wd = w_rd0;
                if (r_i + 1'b1 > r_span) begin
                    n_span = r_i + 1'b1;
                end
                if (r_i == LW'(1)) begin
                    n_pos   = '0;
                    n_cnt   = '0;
                    n_w     = w_want;
                    n_state = (w_want == '0) ? pis_pkg::ST_CLEAR : pis_pkg::ST_EMIT_RD;
                end else begin
                    n_pos   = r_i - 1'b1;
                    n_state = pis_pkg::ST_IDLE;
                end
            end
            pis_pkg::ST_EMIT_RD: begin
                w_re    = 1'b1;
                w_ra0   = AW'(r_cnt);
                n_state = pis_pkg::ST_EMIT_WAIT;
            end
            pis_pkg::ST_EMIT_WAIT: begin
                n_out_idx  = pis_pkg::OUT_W'(w_rd0);
                n_out_last = (r_cnt + 1'b1 == r_w);
                n_ovalid   = 1'b1;
                n_state    = pis_pkg::ST_EMIT_OUT;
            end
            pis_pkg::ST_EMIT_OUT: begin
                if (i_ready) begin
                    n_ovalid = 1'b0;
                    if (r_out_last) begin
                        n_cnt   = '0;
                        n_state = pis_pkg::ST_CLEAR;
                    end else begin
                        n_cnt   = r_cnt + 1'b1;
                        n_state = pis_pkg::ST_EMIT_RD;
                    end
                end
            end
            pis_pkg::ST_CLEAR: begin
                // Only entries below the touched span can differ from identity.
                if (r_cnt < r_span) begin
                    w_we  = 1'b1;
                    w_wa  = AW'(r_cnt);
                    w_wd  = DW'(r_cnt);
                    n_cnt = r_cnt + 1'b1;
                end else begin
                    n_cnt   = '0;
                    n_span  = '0;
                    n_state = pis_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pis_pkg::ST_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            case (i_cfg_idx)
                pis_pkg::CFG_LIST_LENGTH: begin
                    n_list_len = i_cfg_data;
                    n_pos      = '0;
                    if (r_state == pis_pkg::ST_IDLE && r_span != '0) begin
                        n_cnt   = '0;
                        n_state = pis_pkg::ST_CLEAR;
                    end
                end
                pis_pkg::CFG_WANTED_COUNT: begin
                    n_wanted = i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= pis_pkg::ST_CLEAR;
            r_list_len <= LW'(64);
            r_wanted   <= LW'(64);
            r_pos      <= '0;
            r_cnt      <= '0;
            r_span     <= LW'(MAXLEN);
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_list_len <= n_list_len;
            r_wanted   <= n_wanted;
            r_pos      <= n_pos;
            r_cnt      <= n_cnt;
            r_span     <= n_span;
            r_ovalid   <= n_ovalid;
        end
        r_i        <= n_i;
        r_j        <= n_j;
        r_w        <= n_w;
        r_out_idx  <= n_out_idx;
        r_out_last <= n_out_last;
    end

    assign o_valid        = r_ovalid;
    assign o_chosen_index = r_out_idx;
    assign o_last_of_run  = r_out_last;

endmodule
